@@ sv/swrr_pkg.sv @@
// Shared types and constants of the stop-and-wait reassembly receiver.
package swrr_pkg;

  localparam int BUFFER_BYTES = 4096;
  localparam int PACKET_MAX   = 127;
  localparam int QUEUE_DEPTH  = 4;

  localparam int SEQ_W   = 6;
  localparam int LEN_W   = 7;
  localparam int OFS_W   = 12;
  localparam int TOTAL_W = 13;
  localparam int RETRY_W = 8;

  localparam logic [RETRY_W-1:0] MAX_RETRIES_RST = 8'd3;
  localparam logic [RETRY_W-1:0] RETRY_CAP       = 8'd255;

  // Incoming command codes
  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_PACKET  = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;

  // Packet kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_FINAL = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  // Classified operations handed from front to back
  localparam logic [1:0] OP_NOP     = 2'd0;
  localparam logic [1:0] OP_START   = 2'd1;
  localparam logic [1:0] OP_PACKET  = 2'd2;
  localparam logic [1:0] OP_TIMEOUT = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_BUSY     = 3'd0;
  localparam logic [2:0] ST_DONE     = 3'd1;
  localparam logic [2:0] ST_RETRIES  = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_IDLE     = 3'd4;

  typedef struct packed {
    logic [1:0]       command;
    logic [1:0]       packet_kind;
    logic [SEQ_W-1:0] packet_seq;
    logic [LEN_W-1:0] packet_len;
  } rcv_in_t;

  typedef struct packed {
    logic               ack_send;
    logic [SEQ_W-1:0]   ack_seq;
    logic               store_payload;
    logic [OFS_W-1:0]   store_offset;
    logic [2:0]         status;
    logic               final_kind;
    logic [TOTAL_W-1:0] total_length;
  } rcv_out_t;

  typedef struct packed {
    logic [1:0]       op;
    logic             last;
    logic             fin_kind;
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
  } rcv_op_t;

endpackage

@@ sv/swrr_front.sv @@
// Front end: accepts input transactions and classifies them into operations.
module swrr_front (
  input  logic             in_push,
  output logic             in_full,
  input  swrr_pkg::rcv_in_t in_data,
  output logic             q_push,
  output swrr_pkg::rcv_op_t q_item,
  input  logic             q_full
);

  logic [swrr_pkg::LEN_W-1:0] len_sat;

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

  assign len_sat = (32'(in_data.packet_len) > swrr_pkg::PACKET_MAX) ?
                   swrr_pkg::LEN_W'(swrr_pkg::PACKET_MAX) : in_data.packet_len;

  always_comb begin
    q_item.seq      = in_data.packet_seq;
    q_item.len      = len_sat;
    q_item.last     = (in_data.packet_kind == swrr_pkg::KIND_FINAL) ||
                      (in_data.packet_kind == swrr_pkg::KIND_END);
    q_item.fin_kind = (in_data.packet_kind == swrr_pkg::KIND_END);
    unique case (in_data.command)
      swrr_pkg::CMD_START:   q_item.op = swrr_pkg::OP_START;
      swrr_pkg::CMD_PACKET:  q_item.op = (in_data.packet_kind == swrr_pkg::KIND_OTHER) ?
                                         swrr_pkg::OP_NOP : swrr_pkg::OP_PACKET;
      swrr_pkg::CMD_TIMEOUT: q_item.op = swrr_pkg::OP_TIMEOUT;
      default:               q_item.op = swrr_pkg::OP_NOP;
    endcase
  end

endmodule

@@ sv/swrr_queue.sv @@
// Short queue of classified operations between front and back.
module swrr_queue #(
  parameter int DEPTH = swrr_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  swrr_pkg::rcv_op_t push_item,
  output logic              full,
  input  logic              pop,
  output swrr_pkg::rcv_op_t head_item,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  swrr_pkg::rcv_op_t    slot_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign head_item = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ sv/swrr_back.sv @@
// Back end: transfer state, retry counting and the registered result.
module swrr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  swrr_pkg::rcv_op_t  q_item,
  output logic               q_pop,
  input  logic               cfg_we,
  input  logic [swrr_pkg::RETRY_W-1:0] cfg_wdata,
  output logic               out_empty,
  input  logic               out_pop,
  output swrr_pkg::rcv_out_t out_data
);

  localparam int SUM_W = swrr_pkg::TOTAL_W + 1;
  localparam logic [SUM_W-1:0] BUF_LIMIT = SUM_W'(swrr_pkg::BUFFER_BYTES);

  logic [swrr_pkg::RETRY_W-1:0] max_retries_r;
  logic                         active_r, active_nxt;
  logic                         got_first_r, got_first_nxt;
  logic [swrr_pkg::SEQ_W-1:0]   exp_seq_r, exp_seq_nxt;
  logic [swrr_pkg::TOTAL_W-1:0] asm_r, asm_nxt;
  logic [swrr_pkg::RETRY_W-1:0] retry_r, retry_nxt;
  logic                         out_valid_r;
  swrr_pkg::rcv_out_t           out_r, res;

  logic [swrr_pkg::SEQ_W-1:0]   exp_seq;
  logic                         in_order;
  logic [SUM_W-1:0]             sum;
  logic                         overflow;
  logic [swrr_pkg::RETRY_W-1:0] retry_inc;
  logic                         fire;

  // Advance whenever the queue holds an operation and the result slot is free or being drained this cycle
  assign fire      = !q_empty && (!out_valid_r || out_pop);
  assign q_pop     = fire;
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  assign exp_seq   = got_first_r ? exp_seq_r : q_item.seq;
  assign in_order  = (q_item.seq == exp_seq);
  assign sum       = {1'b0, asm_r} + SUM_W'(q_item.len);
  assign overflow  = in_order && (sum > BUF_LIMIT);
  assign retry_inc = (retry_r == swrr_pkg::RETRY_CAP) ? retry_r : retry_r + 1'b1;

  always_comb begin
    active_nxt    = active_r;
    got_first_nxt = got_first_r;
    exp_seq_nxt   = exp_seq_r;
    asm_nxt       = asm_r;
    retry_nxt     = retry_r;
    res           = '0;
    res.status    = active_r ? swrr_pkg::ST_BUSY : swrr_pkg::ST_IDLE;
    unique case (q_item.op)
      swrr_pkg::OP_START: begin
        active_nxt    = 1'b1;
        got_first_nxt = 1'b0;
        exp_seq_nxt   = '0;
        asm_nxt       = '0;
        retry_nxt     = '0;
        res.status    = swrr_pkg::ST_BUSY;
      end
      swrr_pkg::OP_PACKET: begin
        if (active_r) begin
          exp_seq_nxt = exp_seq;
          if (overflow) begin
            active_nxt = 1'b0;
            res.status = swrr_pkg::ST_OVERFLOW;
          end else begin
            res.ack_send = 1'b1;
            res.ack_seq  = q_item.seq;
            retry_nxt    = '0;
            if (in_order) begin
              res.store_payload = 1'b1;
              res.store_offset  = asm_r[swrr_pkg::OFS_W-1:0];
              asm_nxt           = sum[swrr_pkg::TOTAL_W-1:0];
              exp_seq_nxt       = exp_seq + 1'b1;
              got_first_nxt     = 1'b1;
            end
            if (q_item.last) begin
              active_nxt     = 1'b0;
              res.status     = swrr_pkg::ST_DONE;
              res.final_kind = q_item.fin_kind;
            end
          end
        end
      end
      swrr_pkg::OP_TIMEOUT: begin
        if (active_r) begin
          retry_nxt = retry_inc;
          if (retry_inc >= max_retries_r) begin
            active_nxt = 1'b0;
            res.status = swrr_pkg::ST_RETRIES;
          end
        end
      end
      default: begin
      end
    endcase
    res.total_length = asm_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_retries_r <= swrr_pkg::MAX_RETRIES_RST;
      active_r      <= 1'b0;
      got_first_r   <= 1'b0;
      exp_seq_r     <= '0;
      asm_r         <= '0;
      retry_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_retries_r <= cfg_wdata;
      end
      if (fire) begin
        active_r    <= active_nxt;
        got_first_r <= got_first_nxt;
        exp_seq_r   <= exp_seq_nxt;
        asm_r       <= asm_nxt;
        retry_r     <= retry_nxt;
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

endmodule

@@ sv/stop_and_wait_reassembly_receiver_core.sv @@
// Top level of the stop-and-wait reassembly receiver.
//
//   channel  ports                          moves one transaction when
//   -------  -----------------------------  ---------------------------
//   input    in_push, in_full, in_data      in_push && !in_full
//   result   out_empty, out_pop, out_data   out_pop && !out_empty
//   config   cfg_we, cfg_wdata              cfg_we
//
// One event per cycle sustained while results are taken; each event is classified and
// written into the operation queue, then executed into the result register, where its
// result can be taken. The transfer state update in the back end sets the one-event-per-cycle rate.
// Reset (rst_n, synchronous) empties the operation queue and the result register,
// idles the transfer and sets max_retries to 3. A held result stalls the back end;
// the input side keeps taking events until the operation queue fills.
module stop_and_wait_reassembly_receiver_core #(
  parameter int QUEUE_DEPTH = swrr_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  swrr_pkg::rcv_in_t             in_data,
  output logic                          out_empty,
  input  logic                          out_pop,
  output swrr_pkg::rcv_out_t            out_data,
  input  logic                          cfg_we,
  input  logic [swrr_pkg::RETRY_W-1:0]  cfg_wdata
);

  logic              q_push, q_full, q_pop, q_empty;
  swrr_pkg::rcv_op_t q_in, q_head;

  swrr_front u_front (
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_push  (q_push),
    .q_item  (q_in),
    .q_full  (q_full)
  );

  swrr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head_item (q_head),
    .empty     (q_empty)
  );

  swrr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

@@ tb/sv/stop_and_wait_reassembly_receiver_core_tb.sv @@
// Self-checking testbench for the stop-and-wait reassembly receiver core.
`timescale 1ns / 100ps

import swrr_pkg::*;

class reassembly_scoreboard;
  rcv_out_t         expected_results[$];
  int               errors;
  // Predicted transfer state and configuration
  logic [7:0]       retry_limit;
  bit               xfer_active;
  bit               have_first;
  logic [SEQ_W-1:0] next_seq;
  int unsigned      bytes_so_far;
  int unsigned      retries;

  function new();
    errors       = 0;
    retry_limit  = MAX_RETRIES_RST;
    xfer_active  = 1'b0;
    have_first   = 1'b0;
    next_seq     = '0;
    bytes_so_far = 0;
    retries      = 0;
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  // Work out the result of one accepted event and queue it
  function void note_event(rcv_in_t ev);
    rcv_out_t    r;
    int unsigned len;
    bit          overflow;
    r = '0;
    r.status = xfer_active ? ST_BUSY : ST_IDLE;
    len = 32'(ev.packet_len);
    if (len > PACKET_MAX) len = PACKET_MAX;
    overflow = 1'b0;
    if (ev.command == CMD_START) begin
      xfer_active  = 1'b1;
      have_first   = 1'b0;
      next_seq     = '0;
      bytes_so_far = 0;
      retries      = 0;
      r.status     = ST_BUSY;
    end else if (ev.command == CMD_PACKET && xfer_active && ev.packet_kind != KIND_OTHER) begin
      if (!have_first) next_seq = ev.packet_seq;
      if (ev.packet_seq == next_seq) begin
        if (bytes_so_far + len > BUFFER_BYTES) begin
          overflow = 1'b1;
        end else begin
          r.store_payload = 1'b1;
          r.store_offset  = OFS_W'(bytes_so_far);
          bytes_so_far    = bytes_so_far + len;
          next_seq        = next_seq + 1'b1;
          have_first      = 1'b1;
        end
      end
      if (overflow) begin
        xfer_active = 1'b0;
        r.status    = ST_OVERFLOW;
      end else begin
        r.ack_send = 1'b1;
        r.ack_seq  = ev.packet_seq;
        retries    = 0;
        if (ev.packet_kind == KIND_FINAL || ev.packet_kind == KIND_END) begin
          xfer_active  = 1'b0;
          r.status     = ST_DONE;
          r.final_kind = (ev.packet_kind == KIND_END);
        end
      end
    end else if (ev.command == CMD_TIMEOUT && xfer_active) begin
      if (retries < RETRY_CAP) retries++;
      if (retries >= retry_limit) begin
        xfer_active = 1'b0;
        r.status    = ST_RETRIES;
      end
    end
    r.total_length = TOTAL_W'(bytes_so_far);
    expected_results.push_back(r);
  endfunction

  function void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check_result(rcv_out_t act);
    rcv_out_t exp_r;
    if (expected_results.size() == 0) begin
      $display("%0t: result with nothing expected, expected none, actual %p", $time, act);
      errors++;
      return;
    end
    exp_r = expected_results.pop_front();
    compare_field("ack_send", 16'(exp_r.ack_send), 16'(act.ack_send));
    compare_field("ack_seq", 16'(exp_r.ack_seq), 16'(act.ack_seq));
    compare_field("store_payload", 16'(exp_r.store_payload), 16'(act.store_payload));
    compare_field("store_offset", 16'(exp_r.store_offset), 16'(act.store_offset));
    compare_field("status", 16'(exp_r.status), 16'(act.status));
    compare_field("final_kind", 16'(exp_r.final_kind), 16'(act.final_kind));
    compare_field("total_length", 16'(exp_r.total_length), 16'(act.total_length));
  endfunction
endclass

module stop_and_wait_reassembly_receiver_core_tb;

  localparam int CYCLE_LIMIT = 400000;

  logic             clk;
  logic             rst_n;
  logic             in_push;
  logic             in_full;
  rcv_in_t          in_data;
  logic             out_empty;
  logic             out_pop;
  rcv_out_t         out_data;
  logic             cfg_we;
  logic [RETRY_W-1:0] cfg_wdata;

  reassembly_scoreboard sb = new();
  bit quiet = 1'b0;
  int n_sent = 0;
  int cycle_count = 0;

  stop_and_wait_reassembly_receiver_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: take a transaction whenever one is offered, with stall bursts
  initial begin
    int stall_left;
    stall_left = 0;
    out_pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) sb.check_result(out_data);
      if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  function automatic rcv_in_t make_event(logic [1:0] cmd, logic [1:0] kind,
                                         logic [SEQ_W-1:0] seq, logic [LEN_W-1:0] len);
    rcv_in_t ev;
    ev.command     = cmd;
    ev.packet_kind = kind;
    ev.packet_seq  = seq;
    ev.packet_len  = len;
    return ev;
  endfunction

  function automatic logic [SEQ_W-1:0] next_packet_seq();
    return sb.have_first ? sb.next_seq : SEQ_W'($urandom);
  endfunction

  task automatic push_event(rcv_in_t ev);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= ev;
    do @(posedge clk); while (in_full);
    sb.note_event(ev);
    n_sent++;
  endtask

  task automatic push_start();
    push_event(make_event(CMD_START, 2'($urandom), SEQ_W'($urandom), LEN_W'($urandom)));
  endtask

  task automatic push_timeout();
    push_event(make_event(CMD_TIMEOUT, 2'($urandom), SEQ_W'($urandom), LEN_W'($urandom)));
  endtask

  task automatic push_packet(logic [1:0] kind, logic [SEQ_W-1:0] seq, logic [LEN_W-1:0] len);
    push_event(make_event(CMD_PACKET, kind, seq, len));
  endtask

  // Hold the sender until every expected result is back
  task automatic wait_for_drain();
    in_push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_retry_limit(logic [RETRY_W-1:0] v);
    wait_for_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.retry_limit = v;
  endtask

  task automatic run_short_transfer();
    int n;
    int pick;
    push_start();
    n = $urandom_range(1, 8);
    for (int i = 0; i < n && sb.xfer_active; i++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)
        push_timeout();
      else if (pick == 1)
        push_packet(KIND_OTHER, SEQ_W'($urandom), LEN_W'($urandom));
      else if (pick == 2)
        push_packet(KIND_DATA, $urandom_range(0, 1) ? sb.next_seq - 1'b1 : SEQ_W'($urandom),
                    LEN_W'($urandom));
      else
        push_packet(KIND_DATA, next_packet_seq(), LEN_W'($urandom));
    end
    // Leave some transfers open so that the next start restarts them
    if (sb.xfer_active && $urandom_range(0, 6) != 0)
      push_packet($urandom_range(0, 1) ? KIND_FINAL : KIND_END,
                  $urandom_range(0, 4) != 0 ? next_packet_seq() : SEQ_W'($urandom),
                  LEN_W'($urandom));
  endtask

  // Fill the buffer: exactly to the last byte and then past it, or with long packets that may overflow it
  task automatic run_big_transfer(bit exact_fill);
    int n;
    push_start();
    if (exact_fill) begin
      for (int i = 0; i < 32; i++) push_packet(KIND_DATA, next_packet_seq(), LEN_W'(127));
      push_packet(KIND_DATA, next_packet_seq(), LEN_W'(32));
      push_packet(KIND_DATA, next_packet_seq(), LEN_W'(0));
      push_packet(KIND_DATA, next_packet_seq(), LEN_W'(1));
    end else begin
      n = $urandom_range(30, 45);
      for (int i = 0; i < n && sb.xfer_active; i++) begin
        if ($urandom_range(0, 15) == 0)
          push_timeout();
        else
          push_packet(KIND_DATA, next_packet_seq(), LEN_W'($urandom_range(96, 127)));
      end
      if (sb.xfer_active) push_packet(KIND_END, next_packet_seq(), LEN_W'($urandom));
    end
  endtask

  task automatic run_retry_burst();
    int k;
    push_start();
    k = 0;
    while (sb.xfer_active && k < 20) begin
      if ($urandom_range(0, 5) == 0)
        push_packet(KIND_DATA, next_packet_seq(), LEN_W'($urandom));
      else
        push_timeout();
      k++;
    end
  endtask

  task automatic run_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n)
      push_event(make_event(2'($urandom), 2'($urandom), SEQ_W'($urandom), LEN_W'($urandom)));
  endtask

  function automatic logic [RETRY_W-1:0] pick_retry_limit();
    case ($urandom_range(0, 6))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd2;
      3: return 8'd3;
      4: return 8'd255;
      default: return RETRY_W'($urandom_range(1, 255));
    endcase
  endfunction

  initial begin
    int pick;
    int next_cfg_at;
    bit filled;
    rst_n     <= 1'b0;
    in_push   <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Events while idle, then restart and ordering cases
    push_timeout();
    push_packet(KIND_DATA, SEQ_W'(0), LEN_W'(0));
    push_event(make_event(2'd3, KIND_OTHER, SEQ_W'(63), LEN_W'(127)));
    push_start();
    push_event(make_event(CMD_START, KIND_OTHER, SEQ_W'(63), LEN_W'(127)));
    push_packet(KIND_OTHER, SEQ_W'(63), LEN_W'(127));
    push_packet(KIND_DATA, SEQ_W'(63), LEN_W'(127));
    push_packet(KIND_DATA, SEQ_W'(5), LEN_W'(9));
    push_packet(KIND_DATA, SEQ_W'(0), LEN_W'(0));
    push_event(make_event(2'd3, KIND_DATA, SEQ_W'(0), LEN_W'(0)));
    push_timeout();
    push_timeout();
    push_packet(KIND_DATA, SEQ_W'(1), LEN_W'(127));
    push_packet(KIND_FINAL, SEQ_W'(2), LEN_W'(1));
    // Out-of-order end still completes
    push_start();
    push_packet(KIND_DATA, SEQ_W'(10), LEN_W'(3));
    push_packet(KIND_END, SEQ_W'(40), LEN_W'(4));
    push_start();
    repeat (3) push_timeout();
    // Zero limit fails at once; the top limit tolerates a few
    write_retry_limit(8'd0);
    push_start();
    push_timeout();
    write_retry_limit(8'd255);
    push_start();
    push_timeout();
    push_packet(KIND_DATA, SEQ_W'(0), LEN_W'(127));
    push_packet(KIND_END, SEQ_W'(1), LEN_W'(127));
    write_retry_limit(8'd1);
    push_start();
    push_timeout();
    write_retry_limit(MAX_RETRIES_RST);

    next_cfg_at = n_sent + 100;
    filled = 1'b0;
    while (n_sent < 500) begin
      if (n_sent >= next_cfg_at) begin
        write_retry_limit(pick_retry_limit());
        next_cfg_at = n_sent + 100;
      end
      if (n_sent >= 400) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        run_short_transfer();
      end else if (pick < 65) begin
        run_big_transfer(!filled);
        filled = 1'b1;
      end else if (pick < 77) begin
        run_retry_burst();
      end else begin
        run_noise();
      end
    end

    wait_for_drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
